FILE: hw/rtl/wvnq_pkg.sv
// Shared types and constants for the weighted vector normalize/quantize block.
package wvnq_pkg;

    localparam int VALUE_W = 16;
    localparam int WEIGHT_W = 17;
    localparam int FRAC_W = 16;
    localparam int ACC_W = 40;
    localparam int CODE_W = 8;
    localparam int MAG_W = 16;

    localparam logic CFG_SCALAR_MODE = 1'b0;
    localparam logic CFG_OUTSIDE_SCALAR = 1'b1;

    typedef struct packed {
        logic                     outside;
        logic                     mode;
        logic signed [VALUE_W-1:0] oscalar;
        logic signed [ACC_W-1:0]   sx;
        logic signed [ACC_W-1:0]   sy;
        logic signed [ACC_W-1:0]   sz;
    } t_job;

endpackage

FILE: hw/rtl/wvnq_front.sv
// Front end: weighted accumulation of cell vertices and the job queue.
module wvnq_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [wvnq_pkg::VALUE_W-1:0] i_value_x,
    input  logic signed [wvnq_pkg::VALUE_W-1:0] i_value_y,
    input  logic signed [wvnq_pkg::VALUE_W-1:0] i_value_z,
    input  logic        [wvnq_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                                i_last_vertex,
    input  logic                                i_outside,
    input  logic                                i_scalar_mode,
    input  logic signed [wvnq_pkg::VALUE_W-1:0] i_outside_scalar,
    output logic                                o_job_valid,
    output wvnq_pkg::t_job                      o_job,
    input  logic                                i_job_pop
);
    import wvnq_pkg::*;

    localparam int PROD_W = VALUE_W + WEIGHT_W + 1;
    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'((64'sd1 <<< (ACC_W-1)) - 1);
    localparam logic signed [ACC_W:0] ACC_MIN = -ACC_MAX - 1;

    logic signed [ACC_W-1:0] r_sx, r_sy, r_sz;
    logic signed [ACC_W-1:0] n_sx, n_sy, n_sz;
    t_job                    r_q [2];
    logic                    r_wp, r_rp;
    logic [1:0]              r_cnt;
    logic                    w_acc, w_push, w_pop;
    t_job                    w_job;

    function automatic logic signed [ACC_W-1:0] acc_add(
        input logic signed [ACC_W-1:0] s,
        input logic signed [VALUE_W-1:0] v,
        input logic [WEIGHT_W-1:0] w
    );
        logic signed [PROD_W-1:0] p;
        logic signed [ACC_W:0]    t;
        p = PROD_W'(v) * $signed({1'b0, w});
        t = (ACC_W+1)'(s) + (ACC_W+1)'(p);
        if (t > ACC_MAX) begin
            return ACC_MAX[ACC_W-1:0];
        end else if (t < ACC_MIN) begin
            return ACC_MIN[ACC_W-1:0];
        end
        return t[ACC_W-1:0];
    endfunction

    assign o_full = (r_cnt == 2'd2);
    assign w_acc = i_push && !o_full;
    assign w_push = w_acc && (i_outside || i_last_vertex);
    assign w_pop = i_job_pop && (r_cnt != 2'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];

    always_comb begin
        n_sx = acc_add(r_sx, i_value_x, i_weight);
        n_sy = acc_add(r_sy, i_value_y, i_weight);
        n_sz = acc_add(r_sz, i_value_z, i_weight);
        w_job.outside = i_outside;
        w_job.mode = i_scalar_mode;
        w_job.oscalar = i_outside_scalar;
        w_job.sx = n_sx;
        w_job.sy = n_sy;
        w_job.sz = n_sz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_sz <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_acc) begin
                if (i_outside || i_last_vertex) begin
                    r_sx <= '0;
                    r_sy <= '0;
                    r_sz <= '0;
                end else begin
                    r_sx <= n_sx;
                    r_sy <= n_sy;
                    r_sz <= n_sz;
                end
            end
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

FILE: hw/rtl/wvnq_back.sv
// Back end: scalar rounding, magnitude square root, code search and result queue.
module wvnq_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_job_valid,
    input  wvnq_pkg::t_job                       i_job,
    output logic                                 o_job_pop,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic        [wvnq_pkg::CODE_W-1:0]   o_code_x,
    output logic        [wvnq_pkg::CODE_W-1:0]   o_code_y,
    output logic        [wvnq_pkg::CODE_W-1:0]   o_code_z,
    output logic        [wvnq_pkg::MAG_W-1:0]    o_magnitude,
    output logic signed [wvnq_pkg::VALUE_W-1:0]  o_scalar_value
);
    import wvnq_pkg::*;

    localparam int SQ_W = 80;
    localparam int S_W = 84;
    localparam int ROOT_W = 42;
    localparam int REM_W = 45;
    localparam int LHS_W = 100;
    localparam int RHS_W = 96;
    localparam int HALF_W = ACC_W / 2;
    localparam int CH_W = S_W / 4;
    localparam int MA_W = CH_W;
    localparam int MB_W = HALF_W;
    localparam logic [CODE_W-1:0] MID_CODE = CODE_W'(127);

    typedef struct packed {
        logic        [CODE_W-1:0]  cx;
        logic        [CODE_W-1:0]  cy;
        logic        [CODE_W-1:0]  cz;
        logic        [MAG_W-1:0]   mag;
        logic signed [VALUE_W-1:0] sc;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_RINIT, S_ROOT, S_RHS, S_ENK, S_ENM, S_ENC, S_PUT
    } t_state;

    t_state                  r_st;
    t_job                    r_job;
    t_res                    r_res;
    logic [1:0]              r_comp, r_part;
    logic [2:0]              r_bit;
    logic [5:0]              r_cnt;
    logic [SQ_W-1:0]         r_sq [3];
    logic [S_W-1:0]          r_s, r_sh;
    logic [ROOT_W-1:0]       r_root;
    logic [REM_W-1:0]        r_rem;
    logic [RHS_W-1:0]        r_rhs;
    logic [LHS_W-1:0]        r_lhs;
    logic [15:0]             r_kk;
    logic [CODE_W-1:0]       r_q;
    t_res                    r_oq [2];
    logic                    r_owp, r_orp;
    logic [1:0]              r_ocnt;

    logic signed [ACC_W-1:0] w_c;
    logic [ACC_W-1:0]        w_abs;
    logic [MA_W-1:0]         w_ma;
    logic [MB_W-1:0]         w_mb;
    logic [MA_W+MB_W-1:0]    w_prod;
    logic [LHS_W-1:0]        w_sh;
    logic [REM_W-1:0]        w_rem2, w_trial;
    logic [CODE_W-1:0]       w_cand, w_absk, w_qn;
    logic                    w_kpos, w_ok, w_oput, w_opop;
    logic signed [ACC_W:0]   w_t;
    logic signed [ACC_W-FRAC_W:0] w_scl;
    logic signed [VALUE_W-1:0] w_sc;

    always_comb begin
        unique case (r_comp)
            2'd0: w_c = r_job.sx;
            2'd1: w_c = r_job.sy;
            default: w_c = r_job.sz;
        endcase
        w_abs = w_c[ACC_W-1] ? ACC_W'(-w_c) : ACC_W'(w_c);

        if (r_st == S_SQ) begin
            w_ma = MA_W'(r_part == 2'd2 ? w_abs[HALF_W-1:0] : w_abs[ACC_W-1:HALF_W]);
            w_mb = (r_part == 2'd0) ? w_abs[ACC_W-1:HALF_W] : w_abs[HALF_W-1:0];
        end else begin
            w_ma = r_s[r_part*CH_W +: CH_W];
            w_mb = MB_W'(r_kk);
        end
        w_prod = (MA_W+MB_W)'(w_ma) * (MA_W+MB_W)'(w_mb);

        if (r_st == S_SQ) begin
            unique case (r_part)
                2'd0: w_sh = LHS_W'(w_prod) << ACC_W;
                2'd1: w_sh = LHS_W'(w_prod) << (HALF_W + 1);
                default: w_sh = LHS_W'(w_prod);
            endcase
        end else begin
            w_sh = LHS_W'(w_prod) << (r_part * CH_W);
        end

        w_rem2 = {r_rem[REM_W-3:0], r_sh[S_W-1 -: 2]};
        w_trial = {1'b0, r_root, 2'b01};

        w_cand = r_q | (CODE_W'(1) << r_bit);
        w_kpos = w_cand[CODE_W-1];
        w_absk = w_kpos ? CODE_W'({w_cand, 1'b0} - 9'd255)
                        : CODE_W'(9'd255 - {w_cand, 1'b0});
        if (w_kpos) begin
            w_ok = !w_c[ACC_W-1] && (r_lhs <= LHS_W'(r_rhs));
        end else begin
            w_ok = !w_c[ACC_W-1] || (r_lhs >= LHS_W'(r_rhs));
        end
        w_qn = w_ok ? w_cand : r_q;

        w_t = (ACC_W+1)'(i_job.sx) + (ACC_W+1)'(1 << (FRAC_W - 1));
        w_scl = (ACC_W-FRAC_W+1)'(w_t >>> FRAC_W);
        if (w_scl > (ACC_W-FRAC_W+1)'(32767)) begin
            w_sc = 16'sh7fff;
        end else if (w_scl < -(ACC_W-FRAC_W+1)'(32768)) begin
            w_sc = 16'sh8000;
        end else begin
            w_sc = w_scl[VALUE_W-1:0];
        end
    end

    assign o_job_pop = (r_st == S_IDLE) && i_job_valid;
    assign w_oput = (r_st == S_PUT) && (r_ocnt != 2'd2);
    assign w_opop = i_pop && (r_ocnt != 2'd0);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_code_x = r_oq[r_orp].cx;
    assign o_code_y = r_oq[r_orp].cy;
    assign o_code_z = r_oq[r_orp].cz;
    assign o_magnitude = r_oq[r_orp].mag;
    assign o_scalar_value = r_oq[r_orp].sc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_owp <= 1'b0;
            r_orp <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (w_oput) begin
                r_owp <= ~r_owp;
            end
            if (w_opop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(w_oput) - 2'(w_opop);

            unique case (r_st)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_comp <= '0;
                        r_part <= '0;
                        r_s <= '0;
                        r_sq[0] <= '0;
                        r_sq[1] <= '0;
                        r_sq[2] <= '0;
                        r_res <= '0;
                        if (i_job.outside) begin
                            if (i_job.mode) begin
                                r_res.sc <= i_job.oscalar;
                            end else begin
                                r_res.cx <= MID_CODE;
                                r_res.cy <= MID_CODE;
                                r_res.cz <= MID_CODE;
                            end
                            r_st <= S_PUT;
                        end else if (i_job.mode) begin
                            r_res.sc <= w_sc;
                            r_st <= S_PUT;
                        end else begin
                            r_st <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_sq[r_comp] <= r_sq[r_comp] + w_sh[SQ_W-1:0];
                    r_s <= r_s + w_sh[S_W-1:0];
                    if (r_part == 2'd2) begin
                        r_part <= '0;
                        if (r_comp == 2'd2) begin
                            r_st <= S_RINIT;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
                S_RINIT: begin
                    r_sh <= r_s;
                    r_rem <= '0;
                    r_root <= '0;
                    r_cnt <= 6'(S_W / 2 - 1);
                    r_st <= S_ROOT;
                end
                S_ROOT: begin
                    r_sh <= r_sh << 2;
                    if (w_rem2 >= w_trial) begin
                        r_rem <= w_rem2 - w_trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_st <= S_RHS;
                        r_comp <= '0;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_RHS: begin
                    if (r_comp == 2'd0) begin
                        if (|r_root[ROOT_W-1:FRAC_W+MAG_W]) begin
                            r_res.mag <= '1;
                        end else begin
                            r_res.mag <= r_root[FRAC_W +: MAG_W];
                        end
                    end
                    if (r_root[ROOT_W-1:FRAC_W] == '0) begin
                        r_res.cx <= MID_CODE;
                        r_res.cy <= MID_CODE;
                        r_res.cz <= MID_CODE;
                        r_st <= S_PUT;
                    end else begin
                        r_rhs <= (RHS_W'(r_sq[r_comp]) << 16) - (RHS_W'(r_sq[r_comp]) << 9)
                                 + RHS_W'(r_sq[r_comp]);
                        r_q <= '0;
                        r_bit <= 3'd7;
                        r_st <= S_ENK;
                    end
                end
                S_ENK: begin
                    r_kk <= 16'(w_absk) * 16'(w_absk);
                    r_lhs <= '0;
                    r_part <= '0;
                    r_st <= S_ENM;
                end
                S_ENM: begin
                    r_lhs <= r_lhs + w_sh;
                    if (r_part == 2'd3) begin
                        r_st <= S_ENC;
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
                S_ENC: begin
                    r_q <= w_qn;
                    if (r_bit == 3'd0) begin
                        unique case (r_comp)
                            2'd0: r_res.cx <= w_qn;
                            2'd1: r_res.cy <= w_qn;
                            default: r_res.cz <= w_qn;
                        endcase
                        if (r_comp == 2'd2) begin
                            r_st <= S_PUT;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                            r_st <= S_RHS;
                        end
                    end else begin
                        r_bit <= r_bit - 3'd1;
                        r_st <= S_ENK;
                    end
                end
                S_PUT: begin
                    if (r_ocnt != 2'd2) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oput) begin
            r_oq[r_owp] <= r_res;
        end
    end

endmodule

FILE: hw/rtl/weighted_vector_normalize_quantize_top.sv
// Top level of the weighted vector normalize/quantize block.
//
//   channel   direction  handshake             beat
//   vertex    in         i_push / o_full       value_x/y/z, weight, last_vertex, outside
//   texel     out        o_empty / i_pop       code_x/y/z, magnitude, scalar_value
//   config    in         i_cfg_valid / ready   i_cfg_index, i_cfg_data
//
// A vertex beat is taken when i_push is high and o_full is low; the 40-bit sums are registered as it is taken.
// Outside and scalar texels go straight to the result stage in the back end; a vector
// texel runs 9 square steps on one shared multiplier, 42 root steps, then per component
// one setup step and 8 code tests (skipped when the root has no integer part).
// A two-entry job queue decouples the ends; a two-entry result queue buffers the texels.
// Reset is synchronous, active low; no clearing pass is needed.
module weighted_vector_normalize_quantize_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [wvnq_pkg::VALUE_W-1:0]  i_value_x,
    input  logic signed [wvnq_pkg::VALUE_W-1:0]  i_value_y,
    input  logic signed [wvnq_pkg::VALUE_W-1:0]  i_value_z,
    input  logic        [wvnq_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                                 i_last_vertex,
    input  logic                                 i_outside,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic        [wvnq_pkg::CODE_W-1:0]   o_code_x,
    output logic        [wvnq_pkg::CODE_W-1:0]   o_code_y,
    output logic        [wvnq_pkg::CODE_W-1:0]   o_code_z,
    output logic        [wvnq_pkg::MAG_W-1:0]    o_magnitude,
    output logic signed [wvnq_pkg::VALUE_W-1:0]  o_scalar_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic        [wvnq_pkg::VALUE_W-1:0]  i_cfg_data
);
    import wvnq_pkg::*;

    logic                      r_scalar_mode;
    logic signed [VALUE_W-1:0] r_outside_scalar;
    logic                      w_job_valid, w_job_pop;
    t_job                      w_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scalar_mode <= 1'b0;
            r_outside_scalar <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCALAR_MODE: r_scalar_mode <= i_cfg_data[0];
                CFG_OUTSIDE_SCALAR: r_outside_scalar <= i_cfg_data;
                default: r_scalar_mode <= r_scalar_mode;
            endcase
        end
    end

    wvnq_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_value_x        (i_value_x),
        .i_value_y        (i_value_y),
        .i_value_z        (i_value_z),
        .i_weight         (i_weight),
        .i_last_vertex    (i_last_vertex),
        .i_outside        (i_outside),
        .i_scalar_mode    (r_scalar_mode),
        .i_outside_scalar (r_outside_scalar),
        .o_job_valid      (w_job_valid),
        .o_job            (w_job),
        .i_job_pop        (w_job_pop)
    );

    wvnq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_job_valid),
        .i_job          (w_job),
        .o_job_pop      (w_job_pop),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_code_x       (o_code_x),
        .o_code_y       (o_code_y),
        .o_code_z       (o_code_z),
        .o_magnitude    (o_magnitude),
        .o_scalar_value (o_scalar_value)
    );

endmodule

FILE: tb/sv/weighted_vector_normalize_quantize_top_tb.sv
// Testbench for the weighted vector normalize/quantize block: predicted texels checked per beat.
module weighted_vector_normalize_quantize_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wvnq_pkg::*;

    localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [CODE_W-1:0]         cx;
        logic [CODE_W-1:0]         cy;
        logic [CODE_W-1:0]         cz;
        logic [MAG_W-1:0]          mag;
        logic signed [VALUE_W-1:0] sv;
    } t_texel;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_push = 1'b0;
    logic                        o_full;
    logic signed [VALUE_W-1:0]   i_value_x = '0;
    logic signed [VALUE_W-1:0]   i_value_y = '0;
    logic signed [VALUE_W-1:0]   i_value_z = '0;
    logic [WEIGHT_W-1:0]         i_weight = '0;
    logic                        i_last_vertex = 1'b0;
    logic                        i_outside = 1'b0;
    logic                        o_empty;
    logic                        i_pop = 1'b0;
    logic [CODE_W-1:0]           o_code_x, o_code_y, o_code_z;
    logic [MAG_W-1:0]            o_magnitude;
    logic signed [VALUE_W-1:0]   o_scalar_value;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic                        i_cfg_index = CFG_SCALAR_MODE;
    logic [VALUE_W-1:0]          i_cfg_data = '0;

    weighted_vector_normalize_quantize_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    t_texel      texel_q[$];
    logic        mode_r;
    logic [15:0] oscalar_r;
    longint      acc_x, acc_y, acc_z;
    int          errors = 0;
    int          texels_seen = 0;
    int          vertices_sent = 0;
    longint      cycles = 0;
    int          pop_long_pct = 5;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint sat_acc(longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    function automatic logic [127:0] sq_abs(longint v);
        logic [127:0] a;
        a = 128'((v < 0) ? -v : v);
        return a * a;
    endfunction

    function automatic logic [63:0] root_of(logic [127:0] s);
        logic [63:0] r, t;
        r = 0;
        for (int b = ACC_W; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= s) r = t;
        end
        return r;
    endfunction

    // largest q with (2q-255)*sqrt(s) <= 255*c
    function automatic logic [7:0] code_of(longint c, logic [127:0] s);
        logic [7:0] q;
        logic [8:0] t;
        int k;
        logic [159:0] lhs, rhs;
        bit ok;
        q = 0;
        rhs = {32'd0, sq_abs(c)} * 160'd65025;
        for (int b = 7; b >= 0; b--) begin
            t = q | (9'd1 << b);
            k = 2 * int'(t) - 255;
            lhs = {32'd0, s} * 160'(k * k);
            if (k > 0) ok = (c >= 0) && (lhs <= rhs);
            else ok = (c >= 0) || (lhs >= rhs);
            if (ok) q = t[7:0];
        end
        return q;
    endfunction

    function automatic void predict_texel(logic signed [15:0] vx, logic signed [15:0] vy,
                                          logic signed [15:0] vz, logic [16:0] w,
                                          logic last, logic outside);
        t_texel t;
        longint sc;
        logic [127:0] s;
        logic [63:0] r;
        t = '0;
        if (outside) begin
            acc_x = 0; acc_y = 0; acc_z = 0;
            if (mode_r) t.sv = oscalar_r;
            else begin
                t.cx = 8'd127; t.cy = 8'd127; t.cz = 8'd127;
            end
            texel_q = {texel_q, t};
            return;
        end
        acc_x = sat_acc(acc_x + longint'(vx) * longint'({1'b0, w}));
        acc_y = sat_acc(acc_y + longint'(vy) * longint'({1'b0, w}));
        acc_z = sat_acc(acc_z + longint'(vz) * longint'({1'b0, w}));
        if (!last) return;
        if (mode_r) begin
            sc = (acc_x + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
            if (sc > 32767) sc = 32767;
            if (sc < -32768) sc = -32768;
            t.sv = sc[15:0];
        end else begin
            s = sq_abs(acc_x) + sq_abs(acc_y) + sq_abs(acc_z);
            r = root_of(s);
            t.mag = ((r >> FRAC_W) > 65535) ? 16'hFFFF : r[FRAC_W +: 16];
            if (r < (64'd1 << FRAC_W)) begin
                t.cx = 8'd127; t.cy = 8'd127; t.cz = 8'd127;
            end else begin
                t.cx = code_of(acc_x, s);
                t.cy = code_of(acc_y, s);
                t.cz = code_of(acc_z, s);
            end
        end
        acc_x = 0; acc_y = 0; acc_z = 0;
        texel_q = {texel_q, t};
    endfunction

    always @(posedge i_clk) begin
        t_texel e;
        if (i_rst_n && i_pop && !o_empty) begin
            texels_seen++;
            if (texel_q.size() == 0) begin
                errors++;
                $display("%0t unexpected texel %h %h %h %h %h", $time, o_code_x, o_code_y,
                         o_code_z, o_magnitude, o_scalar_value);
            end else begin
                e = texel_q.pop_front();
                if (e != {o_code_x, o_code_y, o_code_z, o_magnitude, o_scalar_value}) begin
                    errors++;
                    $display("%0t texel mismatch exp x=%0d y=%0d z=%0d m=%0d s=%0d", $time,
                             e.cx, e.cy, e.cz, e.mag, e.sv);
                    $display("%0t                act x=%0d y=%0d z=%0d m=%0d s=%0d", $time,
                             o_code_x, o_code_y, o_code_z, o_magnitude, o_scalar_value);
                end
            end
        end
        if (i_rst_n)
            i_pop <= ($urandom_range(99) < pop_long_pct) ? 1'b0 : ($urandom_range(3) != 0);
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 92) return int'($urandom_range(3));
        return int'($urandom_range(40, 8));
    endfunction

    task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                               logic signed [15:0] vz, logic [16:0] w,
                               logic last, logic outside, bit gaps = 1);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0) begin
            i_push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_value_x <= vx; i_value_y <= vy; i_value_z <= vz;
        i_weight <= w; i_last_vertex <= last; i_outside <= outside;
        do @(posedge i_clk); while (o_full);
        predict_texel(vx, vy, vz, w, last, outside);
        vertices_sent++;
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (texel_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_SCALAR_MODE) mode_r = data[0];
        else oscalar_r = data;
    endtask

    task automatic set_mode(logic m, logic [15:0] os);
        drain();
        write_reg(CFG_SCALAR_MODE, {15'd0, m});
        write_reg(CFG_OUTSIDE_SCALAR, os);
    endtask

    function automatic logic [16:0] rand_weight();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 17'h10000;
        if (p == 1) return 17'($urandom_range(17'h1FFFF));
        return 17'($urandom_range(17'h10000));
    endfunction

    function automatic logic [15:0] rand_value();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 16'h8000;
        if (p == 1) return 16'h7FFF;
        if (p == 2) return 16'(int'($urandom_range(3)) - 2);
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic random_cells(int n, bit switch_mode);
        int len;
        logic [15:0] vx;
        while (n > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            if ($urandom_range(15) == 0) begin
                send_vertex(rand_value(), rand_value(), rand_value(), rand_weight(), 1'b0, 1'b1);
                n--;
                continue;
            end
            for (int i = 0; i < len; i++) begin
                vx = rand_value();
                if ($urandom_range(7) == 0) vx = 16'(int'($urandom_range(40)) - 20);
                send_vertex(vx, rand_value(), rand_value(), rand_weight(),
                            i == len - 1, 1'b0);
                n--;
            end
            if (switch_mode && $urandom_range(5) == 0) begin
                set_mode(1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
            end
        end
    endtask

    task automatic test_vector_extremes();
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 17'h10000, 1'b1, 1'b0, 0);
        send_vertex(-16'sh8000, 16'sh0, 16'sh7FFF, 17'h1FFFF, 1'b1, 1'b0, 0);
        send_vertex(16'sh1, 16'sh0, 16'sh0, 17'h08000, 1'b1, 1'b0, 0);
        send_vertex(16'sh1, 16'sh0, 16'sh0, 17'h10000, 1'b1, 1'b0, 0);
        send_vertex(16'sh0, -16'sh1, 16'sh0, 17'h10000, 1'b1, 1'b0, 0);
        send_vertex(16'sh3, 16'sh4, -16'sh5, 17'h0, 1'b1, 1'b0, 0);
        send_vertex(16'sh1, 16'sh2, 16'sh2, 17'h10000, 1'b1, 1'b0, 0);
        send_vertex(16'sh0, 16'sh0, 16'sh0, 17'h0, 1'b0, 1'b1, 0);
        for (int i = 0; i < 8; i++)
            send_vertex(-16'sh8000, 16'sh7FFF, -16'sh8000, 17'h1FFFF, i == 7, 1'b0, 0);
        send_vertex(16'sh100, 16'sh100, 16'sh0, 17'h8000, 1'b0, 1'b0, 0);
        send_vertex(16'sh0, 16'sh0, 16'sh0, 17'h0, 1'b0, 1'b1, 0);
    endtask

    task automatic test_scalar_and_mode_change();
        set_mode(1'b1, 16'h8000);
        send_vertex(16'sh7FFF, 16'sh1, 16'sh1, 17'h1FFFF, 1'b1, 1'b0, 0);
        send_vertex(-16'sh8000, 16'sh0, 16'sh0, 17'h1FFFF, 1'b1, 1'b0, 0);
        send_vertex(-16'sh1, 16'sh0, 16'sh0, 17'h08000, 1'b1, 1'b0, 0);
        send_vertex(16'sh1, 16'sh0, 16'sh0, 17'h08000, 1'b1, 1'b0, 0);
        send_vertex(16'sh0, 16'sh0, 16'sh0, 17'h0, 1'b0, 1'b1, 0);
        set_mode(1'b1, 16'h7FFF);
        send_vertex(16'sh0, 16'sh0, 16'sh0, 17'h0, 1'b0, 1'b1, 0);
        send_vertex(16'sh30, 16'sh40, 16'sh0, 17'h10000, 1'b0, 1'b0, 0);
        drain();
        write_reg(CFG_SCALAR_MODE, 16'd0);
        send_vertex(16'sh0, 16'sh0, 16'sh50, 17'h10000, 1'b1, 1'b0, 0);
        set_mode(1'b0, 16'h0);
    endtask

    task automatic test_random_traffic();
        random_cells(200, 1'b1);
        set_mode(1'b0, 16'h0);
        pop_long_pct = 30;
        random_cells(40, 1'b0);
        pop_long_pct = 5;
        drain();
        random_cells(210, 1'b1);
    endtask

    initial begin
        mode_r = 1'b0; oscalar_r = '0;
        acc_x = 0; acc_y = 0; acc_z = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_mode(1'b0, 16'h0);
        test_vector_extremes();
        test_scalar_and_mode_change();
        test_random_traffic();
        drain();
        $display("Sent %0d vertex beats in vector and scalar modes with outside items,",
                 vertices_sent);
        $display("saturating cells and register changes; %0d texels checked.", texels_seen);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/wvnq_pkg.sv
hw/rtl/wvnq_front.sv
hw/rtl/wvnq_back.sv
hw/rtl/weighted_vector_normalize_quantize_top.sv
tb/sv/weighted_vector_normalize_quantize_top_tb.sv
